// File: src/bea_pkg.sv
// ----------------------------------------------------------------------------
// bea_pkg
// shared types, codes and constants of the battery energy accountant
// ----------------------------------------------------------------------------
package bea_pkg;

   localparam int DEVICES_DEF    = 16;
   localparam int ACTIVITIES_DEF = 4;

   localparam logic [15:0] VOLTAGE_RST  = 16'd3000;
   localparam logic [61:0] CAPACITY_RST = 62'h100_0000_0000;
   localparam logic [16:0] DELTA_RST    = 17'h10000;

   localparam logic [62:0]        CAP62     = 63'h4000_0000_0000_0000;
   localparam logic signed [64:0] FLOOR65   = -65'sh4000_0000_0000_0000;
   localparam logic [23:0]        ELAPSED_MAX = 24'hFF_FFFF;

   typedef enum logic [1:0] {
      ACT_UPDATE  = 2'd0,
      ACT_SET     = 2'd1,
      ACT_DEDUCT  = 2'd2,
      ACT_PUBLISH = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ERR_OK      = 2'd0,
      ERR_NO_ACT  = 2'd1,
      ERR_BAD_ACT = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      CSR_VOLTAGE  = 2'd0,
      CSR_CAPACITY = 2'd1,
      CSR_DELTA    = 2'd2
   } csr_type;

   typedef struct packed {
      logic        active;
      logic [31:0] current;
   } slot_type;

   // residual minus an amount, floored at -2^62
   function automatic logic signed [63:0] lower_res(input logic signed [63:0] r,
                                                     input logic [62:0] a);
      logic signed [64:0] d;
      d = {r[63], r} - $signed({2'b00, a});
      if (d < FLOOR65) begin
         return FLOOR65[63:0];
      end
      return d[63:0];
   endfunction

endpackage

// File: src/bea_cell.sv
// ----------------------------------------------------------------------------
// bea_cell
// one device slot of the draw ring: holds current and active flag
// ----------------------------------------------------------------------------
module bea_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic              load_en,
   input  bea_pkg::slot_type load_slot,
   input  bea_pkg::slot_type nbr_slot,
   output bea_pkg::slot_type slot
);
   import bea_pkg::*;

   slot_type slot_ff;
   slot_type slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (load_en) begin
         slot_in = load_slot;
      end else if (shift_en) begin
         slot_in = nbr_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule

// File: src/battery_energy_accountant.sv
// ----------------------------------------------------------------------------
// battery_energy_accountant
// coulomb counting energy gauge with a ring of device draw slots
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// the rsp_ ports for one cycle with rsp_valid and cannot be held off. An
// update, set-draw or deduct item that runs an accounting pass first takes
// the elapsed time, then the draw ring rotates once past a shared multiply
// pipeline, one slot a cycle, and the pass adds the pipeline drain, the
// residual update, the publish threshold compare and the result cycle. A
// publish mark or a rejected item goes straight to the result state, and a
// pass skipped because the battery is depleted goes there from the elapsed
// time state. Busy drops in the cycle the result shows, so the next item can
// be taken at the edge that ends it. The user must write the csr_ port only
// while busy is low and no result is pending; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module battery_energy_accountant #(
   parameter int DEVICES    = bea_pkg::DEVICES_DEF,
   parameter int ACTIVITIES = bea_pkg::ACTIVITIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // command side
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [3:0]         req_device,
   input  logic               req_activity_valid,
   input  logic [2:0]         req_activity,
   input  logic [31:0]        req_amount,
   input  logic [47:0]        req_time_now,
   // result side
   output logic               rsp_valid,
   output logic signed [62:0] rsp_residual,
   output logic signed [63:0] rsp_consumed,
   output logic               rsp_notify,
   output logic               rsp_depleted,
   output logic [1:0]         rsp_error_code,
   // register writes
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [61:0]        csr_wdata
);
   import bea_pkg::*;

   localparam int CNT_W = (DEVICES > 1) ? $clog2(DEVICES + 1) : 1;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_ELAP  = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_DRAIN = 7'b0001000,
      S_APPLY = 7'b0010000,
      S_THR   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration and gauge state
   logic [15:0]        voltage_ff, voltage_in;
   logic [61:0]        cap_ff, cap_in;
   logic [16:0]        delta_ff, delta_in;
   logic signed [63:0] res_ff, res_in;
   logic signed [63:0] lp_ff, lp_in;
   logic [47:0]        lut_ff, lut_in;

   // captured item
   action_type  action_ff, action_in;
   logic [3:0]  dev_ff, dev_in;
   logic        actv_ff, actv_in;
   logic [31:0] amount_ff, amount_in;
   logic [47:0] now_ff, now_in;
   err_type     err_ff, err_in;

   // pass datapath
   logic [23:0]      elapsed_ff, elapsed_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             v1_ff, v1_in;
   logic [47:0]      cv_ff, cv_in;
   logic             v2_ff, v2_in;
   logic [71:0]      prod_ff, prod_in;
   logic [62:0]      total_ff, total_in;
   logic [48:0]      rhs_a_ff, rhs_a_in;
   logic [46:0]      rhs_b_ff, rhs_b_in;
   logic             notify_ff, notify_in;

   // result registers
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [62:0] rsp_res_ff, rsp_res_in;
   logic signed [63:0] rsp_cons_ff, rsp_cons_in;
   logic               rsp_notify_ff, rsp_notify_in;
   logic               rsp_depl_ff, rsp_depl_in;
   logic [1:0]         rsp_err_ff, rsp_err_in;

   // draw ring, slot 0 is the head that feeds the multiplier
   slot_type slots [DEVICES];
   slot_type load_slot;
   logic     ring_shift;
   logic     ring_load;

   assign ring_shift = (state_ff == S_SCAN);
   assign ring_load  = (state_ff == S_DONE) && (action_ff == ACT_SET) && (err_ff == ERR_OK);
   assign load_slot  = '{active: actv_ff, current: amount_ff};

   for (genvar i = 0; i < DEVICES; i++) begin : g_cell
      bea_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (ring_shift),
         .load_en   (ring_load && ({5'd0, dev_ff} == 9'(i))),
         .load_slot (load_slot),
         .nbr_slot  (slots[(i + 1) % DEVICES]),
         .slot      (slots[i])
      );
   end

   logic [47:0] time_diff;
   logic [63:0] acc_sum;
   logic [62:0] charge;
   logic [63:0] pub_diff;
   logic [79:0] thr_lhs;
   logic [79:0] thr_rhs;

   always_comb begin
      state_in  = state_ff;
      voltage_in = voltage_ff;
      cap_in    = cap_ff;
      delta_in  = delta_ff;
      res_in    = res_ff;
      lp_in     = lp_ff;
      lut_in    = lut_ff;
      action_in = action_ff;
      dev_in    = dev_ff;
      actv_in   = actv_ff;
      amount_in = amount_ff;
      now_in    = now_ff;
      err_in    = err_ff;
      elapsed_in = elapsed_ff;
      cnt_in    = cnt_ff;
      total_in  = total_ff;
      rhs_a_in  = rhs_a_ff;
      rhs_b_in  = rhs_b_ff;
      notify_in = notify_ff;
      rsp_valid_in  = 1'b0;
      rsp_res_in    = rsp_res_ff;
      rsp_cons_in   = rsp_cons_ff;
      rsp_notify_in = rsp_notify_ff;
      rsp_depl_in   = rsp_depl_ff;
      rsp_err_in    = rsp_err_ff;

      // multiply pipeline: current times voltage, then times elapsed ticks
      v1_in   = ring_shift && slots[0].active;
      cv_in   = 48'(slots[0].current * voltage_ff);
      v2_in   = v1_ff;
      prod_in = 72'(cv_ff * elapsed_ff);

      // saturating accumulate of one slot charge
      charge  = (prod_ff > 72'(CAP62)) ? CAP62 : prod_ff[62:0];
      acc_sum = {1'b0, total_ff} + {1'b0, charge};
      if (v2_ff) begin
         total_in = (acc_sum > 64'(CAP62)) ? CAP62 : acc_sum[62:0];
      end

      time_diff = req_time_now;
      if (now_ff > lut_ff) begin
         time_diff = now_ff - lut_ff;
      end else begin
         time_diff = '0;
      end

      // drop since last publish, times 2^16, against delta times capacity
      pub_diff = lp_ff - res_ff;
      thr_lhs  = {pub_diff, 16'd0};
      thr_rhs  = {31'd0, rhs_a_ff} + {1'b0, rhs_b_ff, 32'd0};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               action_in = action_type'(req_action);
               dev_in    = req_device;
               actv_in   = req_activity_valid;
               amount_in = req_amount;
               now_in    = req_time_now;
               err_in    = ERR_OK;
               notify_in = 1'b0;
               state_in  = S_ELAP;
               unique case (action_type'(req_action))
                  ACT_UPDATE: begin
                  end
                  ACT_SET: begin
                     if (!req_activity_valid && (req_amount != '0)) begin
                        err_in   = ERR_NO_ACT;
                        state_in = S_DONE;
                     end
                  end
                  ACT_DEDUCT: begin
                     if (!req_activity_valid ||
                         ({1'b0, req_activity} >= 4'(ACTIVITIES))) begin
                        err_in   = ERR_BAD_ACT;
                        state_in = S_DONE;
                     end else begin
                        res_in = lower_res(res_ff, {31'd0, req_amount});
                     end
                  end
                  ACT_PUBLISH: begin
                     lp_in    = res_ff;
                     state_in = S_DONE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ELAP: begin
            elapsed_in = (time_diff > 48'(ELAPSED_MAX)) ? ELAPSED_MAX : time_diff[23:0];
            rhs_a_in   = 49'(cap_ff[31:0] * delta_ff);
            rhs_b_in   = 47'(cap_ff[61:32] * delta_ff);
            total_in   = '0;
            cnt_in     = '0;
            // depleted battery: no pass at all
            state_in   = (res_ff <= 0) ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DEVICES - 1)) begin
               cnt_in   = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            res_in   = lower_res(res_ff, total_ff);
            lut_in   = now_ff;
            state_in = S_THR;
         end
         S_THR: begin
            if ((res_ff > 0) && (lp_ff >= res_ff) && (thr_lhs >= thr_rhs)) begin
               notify_in = 1'b1;
               lp_in     = res_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_res_in    = res_ff[62:0];
            rsp_cons_in   = {2'b00, cap_ff} - res_ff;
            rsp_notify_in = notify_ff;
            rsp_depl_in   = (res_ff <= 0);
            rsp_err_in    = err_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // the user must make register writes arrive only while idle; the block itself does not enforce it
      if (csr_wr_en) begin
         unique case (csr_type'(csr_index))
            CSR_VOLTAGE: voltage_in = csr_wdata[15:0];
            CSR_CAPACITY: begin
               cap_in = csr_wdata;
               res_in = {2'b00, csr_wdata};
               lp_in  = {2'b00, csr_wdata};
            end
            CSR_DELTA: delta_in = csr_wdata[16:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         voltage_ff   <= VOLTAGE_RST;
         cap_ff       <= CAPACITY_RST;
         delta_ff     <= DELTA_RST;
         res_ff       <= {2'b00, CAPACITY_RST};
         lp_ff        <= {2'b00, CAPACITY_RST};
         lut_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         voltage_ff   <= voltage_in;
         cap_ff       <= cap_in;
         delta_ff     <= delta_in;
         res_ff       <= res_in;
         lp_ff        <= lp_in;
         lut_ff       <= lut_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      dev_ff        <= dev_in;
      actv_ff       <= actv_in;
      amount_ff     <= amount_in;
      now_ff        <= now_in;
      err_ff        <= err_in;
      elapsed_ff    <= elapsed_in;
      cnt_ff        <= cnt_in;
      cv_ff         <= cv_in;
      prod_ff       <= prod_in;
      total_ff      <= total_in;
      rhs_a_ff      <= rhs_a_in;
      rhs_b_ff      <= rhs_b_in;
      notify_ff     <= notify_in;
      rsp_res_ff    <= rsp_res_in;
      rsp_cons_ff   <= rsp_cons_in;
      rsp_notify_ff <= rsp_notify_in;
      rsp_depl_ff   <= rsp_depl_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_residual   = rsp_res_ff;
   assign rsp_consumed   = rsp_cons_ff;
   assign rsp_notify     = rsp_notify_ff;
   assign rsp_depleted   = rsp_depl_ff;
   assign rsp_error_code = rsp_err_ff;

endmodule

// File: src/bea_checker.sv
// ----------------------------------------------------------------------------
// bea_checker
// port level checks of the battery energy accountant
// ----------------------------------------------------------------------------
module bea_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [62:0] rsp_residual,
   input logic               rsp_notify,
   input logic               rsp_depleted,
   input logic [1:0]         rsp_error_code
);
   import bea_pkg::*;

   // accepted transfer makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised after transfer");

   // busy drops exactly when the result shows
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("busy dropped without a result");

   // results never come back to back
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   // a rejected item never notifies
   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error_code != ERR_OK)) |-> !rsp_notify)
      else $error("notify on rejected item");

   // depleted flag follows the residual sign
   a_depleted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_depleted == (rsp_residual[62] || (rsp_residual == '0))))
      else $error("depleted flag disagrees with residual");

endmodule

bind battery_energy_accountant bea_checker u_bea_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_residual   (rsp_residual),
   .rsp_notify     (rsp_notify),
   .rsp_depleted   (rsp_depleted),
   .rsp_error_code (rsp_error_code)
);
